### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the RTL of the pixel generator core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_CLK(lbl, clk, rst, !(expr), msg)

`endif

### hw/rtl/lspg_pkg.sv
// ----------------------------------------------------------------------------
// lspg_pkg
// Constants, types and arithmetic helpers of the LED strip pixel generator.
// ----------------------------------------------------------------------------
package lspg_pkg;

   // Strip geometry
   localparam int STRIP_MAX_LEN = 600;
   localparam int LEN_W      = $clog2(STRIP_MAX_LEN + 1);
   localparam int LENREG_W   = 16;
   localparam int IDX_W      = 10;
   localparam int HUE_BITS   = 8;
   localparam int NUM_W      = LEN_W + HUE_BITS;

   // Stream widths
   localparam int TIME_W      = 48;
   localparam int REQ_TDATA_W = ((IDX_W + TIME_W + 7) / 8) * 8;
   localparam int WORD_W      = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;

   // Time reduction: microseconds to milliseconds, milliseconds modulo a minute
   localparam int US_PER_MS    = 1000;
   localparam int MS_PER_MIN   = 60000;
   localparam int REM_W        = $clog2(US_PER_MS);
   localparam int QM_W         = $clog2(MS_PER_MIN);
   localparam int DIGIT_W      = 4;
   localparam int DIGIT_STAGES = TIME_W / DIGIT_W;
   localparam int PROD_W       = QM_W + 8;

   // Hue offset = floor(P * 256 / 60000) mod 256 = floor(P * 32 / 7500) mod 256
   localparam int OFS_GAIN    = 256 / 8;
   localparam int OFS_DIV     = MS_PER_MIN / 8;
   localparam int OFS_PRE     = $clog2(OFS_GAIN);
   localparam int OFS_NUM_W   = PROD_W + OFS_PRE;
   localparam int OFS_SHIFT   = OFS_NUM_W + $clog2(OFS_DIV);
   localparam int RECIP_W     = OFS_SHIFT - $clog2(OFS_DIV) + 1;
   localparam logic [RECIP_W-1:0] OFS_RECIP =
      RECIP_W'(((64'd1 << OFS_SHIFT) + 64'(OFS_DIV) - 64'd1) / 64'(OFS_DIV));

   // Pipeline stage positions
   localparam int S_MUL      = DIGIT_STAGES + 1;
   localparam int S_OFS      = DIGIT_STAGES + 2;
   localparam int S_WHEEL    = DIGIT_STAGES + 3;
   localparam int S_SCALE    = DIGIT_STAGES + 4;
   localparam int S_OUT      = DIGIT_STAGES + 5;
   localparam int PIPE_DEPTH = S_OUT + 1;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE       = 3'd0,
      CSR_SOLID      = 3'd1,
      CSR_BRIGHTNESS = 3'd2,
      CSR_LIMIT      = 3'd3,
      CSR_SPEED      = 3'd4,
      CSR_ORDER      = 3'd5,
      CSR_REVERSE    = 3'd6,
      CSR_LENGTH     = 3'd7
   } csr_reg_type;

   localparam logic [7:0]          MODE_RST       = 8'd0;
   localparam logic [WORD_W-1:0]   SOLID_RST      = 24'd0;
   localparam logic [7:0]          BRIGHTNESS_RST = 8'd153;
   localparam logic [7:0]          LIMIT_RST      = 8'd255;
   localparam logic [7:0]          SPEED_RST      = 8'd9;
   localparam logic [7:0]          ORDER_RST      = 8'd0;
   localparam logic                REVERSE_RST    = 1'b0;
   localparam logic [LENREG_W-1:0] LENGTH_RST     = 16'd0;

   // Modes
   localparam logic [7:0] MODE_FILL      = 8'd1;
   localparam logic [7:0] MODE_HUE_CYCLE = 8'd2;

   // Byte orders
   localparam logic [7:0] ORDER_GRB = 8'd0;
   localparam logic [7:0] ORDER_RGB = 8'd1;
   localparam logic [7:0] ORDER_BRG = 8'd2;
   localparam logic [7:0] ORDER_RBG = 8'd3;
   localparam logic [7:0] ORDER_GBR = 8'd4;
   localparam logic [7:0] ORDER_BGR = 8'd5;

   // Channel positions in a color triple
   localparam logic [1:0] CH_R = 2'd0;
   localparam logic [1:0] CH_G = 2'd1;
   localparam logic [1:0] CH_B = 2'd2;

   localparam int WHEEL_SPAN = 43;
   localparam int WHEEL_STEP = 6;

   typedef enum logic [2:0] {
      RGN_RED     = 3'd0,
      RGN_YELLOW  = 3'd1,
      RGN_GREEN   = 3'd2,
      RGN_CYAN    = 3'd3,
      RGN_BLUE    = 3'd4,
      RGN_MAGENTA = 3'd5
   } region_type;

   typedef logic [2:0][7:0] color_type;
   typedef logic [2:0][1:0] sel_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QM_W-1:0]  qmod;
   } divacc_type;

   // Exact floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = 17'(x) + 17'(x[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

   // Shift time digits into the divide-by-1000 remainder and keep the
   // quotient modulo one minute of milliseconds.
   function automatic divacc_type digit_step(input divacc_type acc_i,
                                             input logic [DIGIT_W-1:0] digit);
      divacc_type     acc;
      logic [REM_W:0] r2;
      logic [QM_W:0]  q2;
      logic           qb;
      acc = acc_i;
      for (int i = DIGIT_W - 1; i >= 0; i--) begin
         r2 = {acc.rem, digit[i]};
         qb = (r2 >= (REM_W + 1)'(US_PER_MS));
         if (qb) begin
            r2 = r2 - (REM_W + 1)'(US_PER_MS);
         end
         acc.rem = r2[REM_W-1:0];
         q2 = {acc.qmod, qb};
         if (q2 >= (QM_W + 1)'(MS_PER_MIN)) begin
            q2 = q2 - (QM_W + 1)'(MS_PER_MIN);
         end
         acc.qmod = q2[QM_W-1:0];
      end
      return acc;
   endfunction

   // Six-region hue wheel; index CH_R/CH_G/CH_B of the result
   function automatic color_type wheel(input logic [7:0] hue);
      color_type  c;
      region_type rgn;
      logic [7:0] base;
      logic [7:0] rise;
      logic [7:0] fall;
      rgn  = RGN_RED;
      base = 8'd0;
      for (int k = 1; k < 6; k++) begin
         if (hue >= 8'(k * WHEEL_SPAN)) begin
            rgn  = region_type'(3'(k));
            base = 8'(k * WHEEL_SPAN);
         end
      end
      rise = 8'((hue - base) * 8'(WHEEL_STEP));
      fall = 8'hFF - rise;
      c = '0;
      case (rgn)
         RGN_RED: begin
            c[CH_R] = 8'hFF; c[CH_G] = rise;  c[CH_B] = 8'h00;
         end
         RGN_YELLOW: begin
            c[CH_R] = fall;  c[CH_G] = 8'hFF; c[CH_B] = 8'h00;
         end
         RGN_GREEN: begin
            c[CH_R] = 8'h00; c[CH_G] = 8'hFF; c[CH_B] = rise;
         end
         RGN_CYAN: begin
            c[CH_R] = 8'h00; c[CH_G] = fall;  c[CH_B] = 8'hFF;
         end
         RGN_BLUE: begin
            c[CH_R] = rise;  c[CH_G] = 8'h00; c[CH_B] = 8'hFF;
         end
         default: begin
            c[CH_R] = 8'hFF; c[CH_G] = 8'h00; c[CH_B] = fall;
         end
      endcase
      return c;
   endfunction

   // Channel sent in each byte slot, slot 0 first on the wire
   function automatic sel_type byte_sel(input logic [7:0] order);
      sel_type sel;
      unique case (order)
         ORDER_RGB: begin sel[0] = CH_R; sel[1] = CH_G; sel[2] = CH_B; end
         ORDER_BRG: begin sel[0] = CH_B; sel[1] = CH_R; sel[2] = CH_G; end
         ORDER_RBG: begin sel[0] = CH_R; sel[1] = CH_B; sel[2] = CH_G; end
         ORDER_GBR: begin sel[0] = CH_G; sel[1] = CH_B; sel[2] = CH_R; end
         ORDER_BGR: begin sel[0] = CH_B; sel[1] = CH_G; sel[2] = CH_R; end
         default:   begin sel[0] = CH_G; sel[1] = CH_R; sel[2] = CH_B; end
      endcase
      return sel;
   endfunction

endpackage

### hw/rtl/led_strip_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// led_strip_pixel_generator_core
// Per-pixel strip word generator: solid or rainbow color (black in other modes), scaled, reordered.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Content
//  req      in         req_tvalid/req_tready  pixel index, frame time (us)
//  rsp      out        rsp_tvalid/rsp_tready  strip word, past-end flag
//  csr      in         csr_we                 register index, write data
//
//  One transaction per clock while rsp_tready is high; the path to rsp_tvalid
//  runs through 18 register stages: the entry register, 12 stages that reduce
//  time_us four bits a stage, and five stages of math.
//  reset (synchronous) clears all valid bits and loads register defaults.
//  With rsp_tready low the output holds; empty stages behind it keep filling,
//  and req_tready falls only once every stage holds a transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_strip_pixel_generator_core (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: pixel_index [9:0], time_us [57:10], zero pad above
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lspg_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata: pixel_word [23:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lspg_pkg::WORD_W-1:0]        rsp_tdata,
   // rsp_tuser: past_end [0]
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [lspg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lspg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef struct packed {
      logic                             past;
      logic [lspg_pkg::TIME_W-1:0]      tim;
      lspg_pkg::divacc_type             acc;
      logic [lspg_pkg::NUM_W-1:0]       num;
      logic [lspg_pkg::HUE_BITS-1:0]    quo;
   } front_type;

   typedef struct packed {
      logic                             past;
      logic [lspg_pkg::HUE_BITS-1:0]    quo;
      logic [lspg_pkg::PROD_W-1:0]      prod;
   } mul_type;

   typedef struct packed {
      logic                             past;
      logic [lspg_pkg::HUE_BITS-1:0]    quo;
      logic [7:0]                       ofs;
   } ofs_type;

   typedef struct packed {
      logic                             past;
      lspg_pkg::color_type              chan;
   } chan_type;

   typedef struct packed {
      logic                             past;
      logic [2:0][15:0]                 prod;
   } scaled_type;

   typedef struct packed {
      logic                             past;
      logic [lspg_pkg::WORD_W-1:0]      word;
   } out_type;

   // Configuration registers
   logic [7:0]                      mode_ff, mode_in;
   logic [lspg_pkg::WORD_W-1:0]     solid_ff, solid_in;
   logic [7:0]                      bright_ff, bright_in;
   logic [7:0]                      limit_ff, limit_in;
   logic [7:0]                      speed_ff, speed_in;
   logic [7:0]                      order_ff, order_in;
   logic                            reverse_ff, reverse_in;
   logic [lspg_pkg::LENREG_W-1:0]   length_ff, length_in;
   logic [7:0]                      scale_ff, scale_in;

   logic [lspg_pkg::LEN_W-1:0]      len_clamp;

   // Pipeline control
   logic [lspg_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [lspg_pkg::PIPE_DEPTH:0]   rdy;

   // Pipeline payload
   front_type  front_ff [lspg_pkg::DIGIT_STAGES+1];
   front_type  front_in [lspg_pkg::DIGIT_STAGES+1];
   mul_type    mul_ff, mul_in;
   ofs_type    ofs_ff, ofs_in;
   chan_type   chan_ff, chan_in;
   scaled_type scaled_ff, scaled_in;
   out_type    out_ff, out_in;

   logic [lspg_pkg::IDX_W-1:0]      req_idx;
   logic [lspg_pkg::LENREG_W-1:0]   pos_wide;
   logic [lspg_pkg::LEN_W-1:0]      pos;
   logic [lspg_pkg::OFS_NUM_W+lspg_pkg::RECIP_W-1:0] ofs_wide;
   logic [7:0]                      hue;
   lspg_pkg::sel_type               sel;

   // One time digit and, in the first stages, one hue quotient bit
   function automatic front_type front_step(input front_type f_i, input int s,
                                            input logic [lspg_pkg::LEN_W-1:0] len);
      front_type                   f;
      logic [lspg_pkg::NUM_W-1:0]  divisor;
      logic                        hit;
      f = f_i;
      f.acc = lspg_pkg::digit_step(f_i.acc,
                                   f_i.tim[lspg_pkg::TIME_W-1 -: lspg_pkg::DIGIT_W]);
      f.tim = f_i.tim << lspg_pkg::DIGIT_W;
      if (s <= lspg_pkg::HUE_BITS) begin
         divisor = lspg_pkg::NUM_W'(len) << (lspg_pkg::HUE_BITS - s);
         hit = (f_i.num >= divisor);
         if (hit) begin
            f.num = f_i.num - divisor;
         end
         f.quo = {f_i.quo[lspg_pkg::HUE_BITS-2:0], hit};
      end
      return f;
   endfunction

   // ---------------------------------------------------------------- config
   always_comb begin
      mode_in    = mode_ff;
      solid_in   = solid_ff;
      bright_in  = bright_ff;
      limit_in   = limit_ff;
      speed_in   = speed_ff;
      order_in   = order_ff;
      reverse_in = reverse_ff;
      length_in  = length_ff;
      if (csr_we) begin
         unique case (lspg_pkg::csr_reg_type'(csr_index))
            lspg_pkg::CSR_MODE:       mode_in    = csr_wdata[7:0];
            lspg_pkg::CSR_SOLID:      solid_in   = csr_wdata[lspg_pkg::WORD_W-1:0];
            lspg_pkg::CSR_BRIGHTNESS: bright_in  = csr_wdata[7:0];
            lspg_pkg::CSR_LIMIT:      limit_in   = csr_wdata[7:0];
            lspg_pkg::CSR_SPEED:      speed_in   = csr_wdata[7:0];
            lspg_pkg::CSR_ORDER:      order_in   = csr_wdata[7:0];
            lspg_pkg::CSR_REVERSE:    reverse_in = csr_wdata[0];
            lspg_pkg::CSR_LENGTH:     length_in  = csr_wdata[lspg_pkg::LENREG_W-1:0];
            default:                  mode_in    = mode_ff;
         endcase
      end
      scale_in = lspg_pkg::div255(16'(bright_ff) * 16'(limit_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= lspg_pkg::MODE_RST;
         solid_ff   <= lspg_pkg::SOLID_RST;
         bright_ff  <= lspg_pkg::BRIGHTNESS_RST;
         limit_ff   <= lspg_pkg::LIMIT_RST;
         speed_ff   <= lspg_pkg::SPEED_RST;
         order_ff   <= lspg_pkg::ORDER_RST;
         reverse_ff <= lspg_pkg::REVERSE_RST;
         length_ff  <= lspg_pkg::LENGTH_RST;
      end else begin
         mode_ff    <= mode_in;
         solid_ff   <= solid_in;
         bright_ff  <= bright_in;
         limit_ff   <= limit_in;
         speed_ff   <= speed_in;
         order_ff   <= order_in;
         reverse_ff <= reverse_in;
         length_ff  <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      scale_ff <= scale_in;
   end

   assign len_clamp = (length_ff > lspg_pkg::LENREG_W'(lspg_pkg::STRIP_MAX_LEN))
                    ? lspg_pkg::LEN_W'(lspg_pkg::STRIP_MAX_LEN)
                    : length_ff[lspg_pkg::LEN_W-1:0];

   // -------------------------------------------------------- flow control
   // A stage takes a new transaction when it is empty or its own
   // transaction moves on in the same cycle.
   always_comb begin
      rdy[lspg_pkg::PIPE_DEPTH] = rsp_tready;
      for (int s = lspg_pkg::PIPE_DEPTH - 1; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
      vld_in[0] = rdy[0] ? req_tvalid : vld_ff[0];
      for (int s = 1; s < lspg_pkg::PIPE_DEPTH; s++) begin
         vld_in[s] = rdy[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = rdy[0];

   // ------------------------------------------------- entry and time digits
   assign req_idx  = req_tdata[lspg_pkg::IDX_W-1:0];
   assign pos_wide = reverse_ff
                   ? lspg_pkg::LENREG_W'(len_clamp) - 16'd1 - lspg_pkg::LENREG_W'(req_idx)
                   : lspg_pkg::LENREG_W'(req_idx);
   assign pos      = pos_wide[lspg_pkg::LEN_W-1:0];

   always_comb begin
      front_in[0].past = (lspg_pkg::LENREG_W'(req_idx) >= lspg_pkg::LENREG_W'(len_clamp));
      front_in[0].tim  = req_tdata[lspg_pkg::IDX_W +: lspg_pkg::TIME_W];
      front_in[0].acc  = '0;
      front_in[0].num  = {pos, lspg_pkg::HUE_BITS'(0)};
      front_in[0].quo  = '0;
      for (int s = 1; s <= lspg_pkg::DIGIT_STAGES; s++) begin
         front_in[s] = front_step(front_ff[s-1], s, len_clamp);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= lspg_pkg::DIGIT_STAGES; s++) begin
         if (rdy[s]) begin
            front_ff[s] <= front_in[s];
         end
      end
   end

   // ------------------------------------------------------ offset and hue
   assign mul_in.past = front_ff[lspg_pkg::DIGIT_STAGES].past;
   assign mul_in.quo  = front_ff[lspg_pkg::DIGIT_STAGES].quo;
   assign mul_in.prod = lspg_pkg::PROD_W'(front_ff[lspg_pkg::DIGIT_STAGES].acc.qmod)
                      * lspg_pkg::PROD_W'(speed_ff);

   // floor(P * 32 / 7500) through a rounded-up reciprocal; keep the low byte
   assign ofs_wide   = {mul_ff.prod, lspg_pkg::OFS_PRE'(0)} * lspg_pkg::OFS_RECIP;
   assign ofs_in.past = mul_ff.past;
   assign ofs_in.quo  = mul_ff.quo;
   assign ofs_in.ofs  = ofs_wide[lspg_pkg::OFS_SHIFT +: 8];

   assign hue = ofs_ff.quo + ofs_ff.ofs;

   always_comb begin
      chan_in.past = ofs_ff.past;
      case (mode_ff)
         lspg_pkg::MODE_FILL:      chan_in.chan = {solid_ff[7:0], solid_ff[15:8],
                                                   solid_ff[23:16]};
         lspg_pkg::MODE_HUE_CYCLE: chan_in.chan = lspg_pkg::wheel(hue);
         default:                  chan_in.chan = '0;
      endcase
   end

   // ----------------------------------------------------- scale and order
   assign sel = lspg_pkg::byte_sel(order_ff);

   always_comb begin
      scaled_in.past = chan_ff.past;
      for (int k = 0; k < 3; k++) begin
         scaled_in.prod[k] = 16'(chan_ff.chan[sel[k]]) * 16'(scale_ff);
      end
   end

   assign out_in.past = scaled_ff.past;
   assign out_in.word = scaled_ff.past ? '0
                      : {lspg_pkg::div255(scaled_ff.prod[0]),
                         lspg_pkg::div255(scaled_ff.prod[1]),
                         lspg_pkg::div255(scaled_ff.prod[2])};

   always_ff @(posedge clock) begin
      if (rdy[lspg_pkg::S_MUL]) begin
         mul_ff <= mul_in;
      end
      if (rdy[lspg_pkg::S_OFS]) begin
         ofs_ff <= ofs_in;
      end
      if (rdy[lspg_pkg::S_WHEEL]) begin
         chan_ff <= chan_in;
      end
      if (rdy[lspg_pkg::S_SCALE]) begin
         scaled_ff <= scaled_in;
      end
      if (rdy[lspg_pkg::S_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vld_ff[lspg_pkg::S_OUT];
   assign rsp_tdata  = out_ff.word;
   assign rsp_tuser  = out_ff.past;

   // ------------------------------------------------------------ checks
   `ASSERT_CLK(a_past_word_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "past-end transaction carries a nonzero word")
   `ASSERT_CLK(a_stall_only_full, clock, reset, !req_tready |-> &vld_ff, "input stalled while a stage is empty")
   `ASSERT_CLK(a_accept_enters, clock, reset, req_tvalid && req_tready |=> vld_ff[0], "accepted transaction missing from entry stage")

endmodule
